[rtl/core/frame_difference_peak_tracker_macros.svh]
// assertion macros for the frame difference peak tracker
`ifndef FRAME_DIFFERENCE_PEAK_TRACKER_MACROS_SVH
`define FRAME_DIFFERENCE_PEAK_TRACKER_MACROS_SVH

// condition holds in the same cycle
`define FDPT_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// condition holds in the next cycle
`define FDPT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/core/fdpt_pkg.sv]
// shared constants and types of the frame difference peak tracker
`default_nettype none

package fdpt_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned PortCoordW   = 12;
  localparam int unsigned PixW         = 8;
  localparam int unsigned ThrW         = 8;
  localparam int unsigned CntW         = 22;
  localparam int unsigned SubW         = 24;
  localparam int unsigned NumCh        = 3;
  localparam int unsigned CfgIdxW      = 1;

  typedef logic signed [9:0] diff_t;
  typedef logic signed [8:0] rise_t;
  typedef logic [CntW-1:0]   cnt_t;
  typedef logic [SubW-1:0]   sub_t;
  typedef logic [1:0]        chan_t;
  typedef logic [PixW-1:0]   pix_t;
  typedef logic [ThrW-1:0]   thr_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  localparam cfg_idx_t CFG_MAIN_THR = 1'b0;
  localparam cfg_idx_t CFG_SUB_THR  = 1'b1;

  localparam rise_t RiseRst = -9'sd1;
  localparam diff_t FallRst = 10'sd256;
  localparam cnt_t  CntMax  = '1;
  localparam sub_t  SubMax  = '1;

endpackage

`default_nettype wire

[rtl/core/frame_difference_peak_tracker.sv]
// frame difference peak tracker: per-channel peak rise and fall with counts
// a pixel is registered, then folded into the frame state in the next cycle; an end-of-frame
// pixel may wait there, and its fold loads three results that start in the cycle after
// throughput: one pixel per cycle but for that wait; the three results leave one per cycle while
// out_ready_i is high; a further end-of-frame pixel waits only while the previous three are queued
// reset: asynchronous, clears thresholds and frame state, no item or result held
`default_nettype none

`include "frame_difference_peak_tracker_macros.svh"

module frame_difference_peak_tracker #(
  parameter int unsigned COORD_BITS = fdpt_pkg::CoordBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  fdpt_pkg::cfg_idx_t                  cfg_idx_i,
  input  fdpt_pkg::thr_t                      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fdpt_pkg::pix_t                      old_red_i,
  input  fdpt_pkg::pix_t                      old_green_i,
  input  fdpt_pkg::pix_t                      old_blue_i,
  input  fdpt_pkg::pix_t                      new_red_i,
  input  fdpt_pkg::pix_t                      new_green_i,
  input  fdpt_pkg::pix_t                      new_blue_i,
  input  logic [fdpt_pkg::PortCoordW-1:0]     row_i,
  input  logic [fdpt_pkg::PortCoordW-1:0]     column_i,
  input  logic                                excluded_i,
  input  logic                                frame_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fdpt_pkg::chan_t                     channel_o,
  output logic signed [8:0]                   peak_rise_o,
  output logic [fdpt_pkg::PortCoordW-1:0]     rise_row_o,
  output logic [fdpt_pkg::PortCoordW-1:0]     rise_column_o,
  output logic signed [9:0]                   peak_fall_o,
  output logic [fdpt_pkg::PortCoordW-1:0]     fall_row_o,
  output logic [fdpt_pkg::PortCoordW-1:0]     fall_column_o,
  output fdpt_pkg::cnt_t                      rises_over_o,
  output fdpt_pkg::cnt_t                      falls_under_o,
  output fdpt_pkg::sub_t                      sub_total_o,
  output logic                                last_o
);

  import fdpt_pkg::*;

  localparam int unsigned LocW = (COORD_BITS < PortCoordW) ? COORD_BITS : PortCoordW;
  typedef logic [LocW-1:0] loc_t;

  // configuration
  thr_t main_thr_q, sub_thr_q;

  // input register
  logic stg_vld_q;
  pix_t stg_old_q [NumCh];
  pix_t stg_new_q [NumCh];
  loc_t stg_row_q, stg_col_q;
  logic stg_excl_q, stg_fend_q;

  // frame state
  rise_t max_q [NumCh];
  diff_t min_q [NumCh];
  loc_t  max_row_q [NumCh];
  loc_t  max_col_q [NumCh];
  loc_t  min_row_q [NumCh];
  loc_t  min_col_q [NumCh];
  cnt_t  above_q [NumCh];
  cnt_t  below_q [NumCh];
  sub_t  sub_q;

  rise_t max_d [NumCh];
  diff_t min_d [NumCh];
  loc_t  max_row_d [NumCh];
  loc_t  max_col_d [NumCh];
  loc_t  min_row_d [NumCh];
  loc_t  min_col_d [NumCh];
  cnt_t  above_d [NumCh];
  cnt_t  below_d [NumCh];
  sub_t  sub_d;

  // result snapshot
  logic  snap_vld_q;
  chan_t ch_q;
  rise_t snap_rise_q [NumCh];
  diff_t snap_fall_q [NumCh];
  loc_t  snap_rrow_q [NumCh];
  loc_t  snap_rcol_q [NumCh];
  loc_t  snap_frow_q [NumCh];
  loc_t  snap_fcol_q [NumCh];
  cnt_t  snap_above_q [NumCh];
  cnt_t  snap_below_q [NumCh];
  sub_t  snap_sub_q;

  logic snap_free, advance, in_acc, out_acc;

  assign out_acc   = snap_vld_q && out_ready_i;
  assign snap_free = !snap_vld_q || (out_ready_i && (ch_q == CH_BLUE));
  assign advance   = stg_vld_q && (!stg_fend_q || snap_free);
  assign in_ready_o = !stg_vld_q || advance;
  assign in_acc    = in_valid_i && in_ready_o;

  // per-channel update
  always_comb begin
    diff_t      diff;
    diff_t      mthr, sthr;
    logic       rise_up, fall_dn;
    logic [2:0] n_sub;
    logic [SubW:0] sub_sum;
    mthr  = diff_t'({2'b00, main_thr_q});
    sthr  = diff_t'({2'b00, sub_thr_q});
    n_sub = '0;
    for (int c = 0; c < NumCh; c++) begin
      diff = diff_t'({2'b00, stg_new_q[c]}) - diff_t'({2'b00, stg_old_q[c]});
      rise_up = !stg_excl_q && (diff > diff_t'(max_q[c]));
      fall_dn = !stg_excl_q && (diff < min_q[c]);
      max_d[c]     = max_q[c];
      max_row_d[c] = max_row_q[c];
      max_col_d[c] = max_col_q[c];
      above_d[c]   = above_q[c];
      min_d[c]     = min_q[c];
      min_row_d[c] = min_row_q[c];
      min_col_d[c] = min_col_q[c];
      below_d[c]   = below_q[c];
      if (rise_up) begin
        max_d[c]     = diff[8:0];
        max_row_d[c] = stg_row_q;
        max_col_d[c] = stg_col_q;
        if (diff > mthr && above_q[c] != CntMax) begin
          above_d[c] = above_q[c] + cnt_t'(1);
        end
        if (diff > sthr) begin
          n_sub = n_sub + 3'd1;
        end
      end
      if (fall_dn) begin
        min_d[c]     = diff;
        min_row_d[c] = stg_row_q;
        min_col_d[c] = stg_col_q;
        if (diff < -mthr && below_q[c] != CntMax) begin
          below_d[c] = below_q[c] + cnt_t'(1);
        end
        if (diff < -sthr) begin
          n_sub = n_sub + 3'd1;
        end
      end
    end
    sub_sum = {1'b0, sub_q} + (SubW+1)'(n_sub);
    sub_d   = sub_sum[SubW] ? SubMax : sub_sum[SubW-1:0];
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_thr_q <= '0;
      sub_thr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAIN_THR: main_thr_q <= cfg_wdata_i;
        CFG_SUB_THR:  sub_thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_acc) begin
      stg_vld_q <= 1'b1;
    end else if (advance) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stg_old_q[0] <= old_red_i;
      stg_old_q[1] <= old_green_i;
      stg_old_q[2] <= old_blue_i;
      stg_new_q[0] <= new_red_i;
      stg_new_q[1] <= new_green_i;
      stg_new_q[2] <= new_blue_i;
      stg_row_q    <= row_i[LocW-1:0];
      stg_col_q    <= column_i[LocW-1:0];
      stg_excl_q   <= excluded_i;
      stg_fend_q   <= frame_end_i;
    end
  end

  // frame state, cleared after the last pixel of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumCh; c++) begin
        max_q[c]     <= RiseRst;
        min_q[c]     <= FallRst;
        max_row_q[c] <= '0;
        max_col_q[c] <= '0;
        min_row_q[c] <= '0;
        min_col_q[c] <= '0;
        above_q[c]   <= '0;
        below_q[c]   <= '0;
      end
      sub_q <= '0;
    end else if (advance) begin
      if (stg_fend_q) begin
        for (int c = 0; c < NumCh; c++) begin
          max_q[c]     <= RiseRst;
          min_q[c]     <= FallRst;
          max_row_q[c] <= '0;
          max_col_q[c] <= '0;
          min_row_q[c] <= '0;
          min_col_q[c] <= '0;
          above_q[c]   <= '0;
          below_q[c]   <= '0;
        end
        sub_q <= '0;
      end else begin
        max_q     <= max_d;
        min_q     <= min_d;
        max_row_q <= max_row_d;
        max_col_q <= max_col_d;
        min_row_q <= min_row_d;
        min_col_q <= min_col_d;
        above_q   <= above_d;
        below_q   <= below_d;
        sub_q     <= sub_d;
      end
    end
  end

  // result sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      ch_q       <= CH_RED;
    end else if (advance && stg_fend_q) begin
      snap_vld_q <= 1'b1;
      ch_q       <= CH_RED;
    end else if (out_acc) begin
      if (ch_q == CH_BLUE) begin
        snap_vld_q <= 1'b0;
        ch_q       <= CH_RED;
      end else begin
        ch_q <= ch_q + chan_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stg_fend_q) begin
      snap_rise_q  <= max_d;
      snap_fall_q  <= min_d;
      snap_rrow_q  <= max_row_d;
      snap_rcol_q  <= max_col_d;
      snap_frow_q  <= min_row_d;
      snap_fcol_q  <= min_col_d;
      snap_above_q <= above_d;
      snap_below_q <= below_d;
      snap_sub_q   <= sub_d;
    end
  end

  assign out_valid_o   = snap_vld_q;
  assign channel_o     = ch_q;
  assign peak_rise_o   = snap_rise_q[ch_q];
  assign rise_row_o    = PortCoordW'(snap_rrow_q[ch_q]);
  assign rise_column_o = PortCoordW'(snap_rcol_q[ch_q]);
  assign peak_fall_o   = snap_fall_q[ch_q];
  assign fall_row_o    = PortCoordW'(snap_frow_q[ch_q]);
  assign fall_column_o = PortCoordW'(snap_fcol_q[ch_q]);
  assign rises_over_o  = snap_above_q[ch_q];
  assign falls_under_o = snap_below_q[ch_q];
  assign sub_total_o   = snap_sub_q;
  assign last_o        = snap_vld_q && (ch_q == CH_BLUE);

  `FDPT_ASSERT_NOW(a_chan_range, snap_vld_q, ch_q == CH_RED || ch_q == CH_GREEN || ch_q == CH_BLUE, "result channel out of range")
  `FDPT_ASSERT_NOW(a_last_blue, out_valid_o, last_o == (channel_o == CH_BLUE), "last flag not on blue result")
  `FDPT_ASSERT_NEXT(a_snap_load, advance && stg_fend_q, snap_vld_q && ch_q == CH_RED, "frame results not started after last pixel")
  `FDPT_ASSERT_NEXT(a_end_stall, stg_vld_q && stg_fend_q && !snap_free, stg_vld_q && stg_fend_q, "last pixel lost while results pending")

endmodule

`default_nettype wire

[tb/sv/tb_frame_difference_peak_tracker.sv]
// testbench for the frame difference peak tracker: predicted per-channel peaks and counts
`timescale 1ns / 100ps

module tb_frame_difference_peak_tracker;
  import fdpt_pkg::*;

  typedef struct packed {
    pix_t [2:0]  old_px;
    pix_t [2:0]  new_px;
    logic [11:0] row;
    logic [11:0] col;
    logic        excl;
    logic        fend;
  } pixel_t;

  typedef struct packed {
    chan_t       ch;
    rise_t       rise;
    logic [11:0] rise_row;
    logic [11:0] rise_col;
    diff_t       fall;
    logic [11:0] fall_row;
    logic [11:0] fall_col;
    cnt_t        over;
    cnt_t        under;
    sub_t        subt;
    logic        last;
  } frame_peak_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cfg_idx_t cfg_idx_i;
  thr_t cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  pixel_t px_drv;
  logic out_valid_o;
  logic out_ready_i;
  chan_t channel_o;
  logic signed [8:0] peak_rise_o;
  logic [11:0] rise_row_o, rise_column_o;
  logic signed [9:0] peak_fall_o;
  logic [11:0] fall_row_o, fall_column_o;
  cnt_t rises_over_o, falls_under_o;
  sub_t sub_total_o;
  logic last_o;

  frame_difference_peak_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .old_red_i     (px_drv.old_px[0]),
    .old_green_i   (px_drv.old_px[1]),
    .old_blue_i    (px_drv.old_px[2]),
    .new_red_i     (px_drv.new_px[0]),
    .new_green_i   (px_drv.new_px[1]),
    .new_blue_i    (px_drv.new_px[2]),
    .row_i         (px_drv.row),
    .column_i      (px_drv.col),
    .excluded_i    (px_drv.excl),
    .frame_end_i   (px_drv.fend),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .peak_rise_o   (peak_rise_o),
    .rise_row_o    (rise_row_o),
    .rise_column_o (rise_column_o),
    .peak_fall_o   (peak_fall_o),
    .fall_row_o    (fall_row_o),
    .fall_column_o (fall_column_o),
    .rises_over_o  (rises_over_o),
    .falls_under_o (falls_under_o),
    .sub_total_o   (sub_total_o),
    .last_o        (last_o)
  );

  // predictor state
  thr_t        thr_main, thr_sub;
  int          hi_diff[3], lo_diff[3];
  logic [11:0] hi_row[3], hi_col[3], lo_row[3], lo_col[3];
  cnt_t        rise_cnt[3], fall_cnt[3];
  sub_t        sub_cnt;
  frame_peak_t peaks_due[$];

  int fails;
  bit tx_steady, rx_steady;
  int hold_request, hold_left, stall_left;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int draw_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic void clear_frame();
    for (int c = 0; c < 3; c++) begin
      hi_diff[c] = -1;
      lo_diff[c] = 256;
      hi_row[c] = '0;
      hi_col[c] = '0;
      lo_row[c] = '0;
      lo_col[c] = '0;
      rise_cnt[c] = '0;
      fall_cnt[c] = '0;
    end
    sub_cnt = '0;
  endfunction

  function automatic void fold_pixel(input pixel_t p);
    int d[3];
    frame_peak_t r;
    for (int c = 0; c < 3; c++) d[c] = int'(p.new_px[c]) - int'(p.old_px[c]);
    if (!p.excl) begin
      for (int c = 0; c < 3; c++) begin
        if (d[c] > hi_diff[c]) begin
          hi_diff[c] = d[c];
          hi_row[c] = p.row;
          hi_col[c] = p.col;
          if (d[c] > int'(thr_main) && rise_cnt[c] != CntMax) rise_cnt[c]++;
          if (d[c] > int'(thr_sub) && sub_cnt != SubMax) sub_cnt++;
        end
      end
      for (int c = 0; c < 3; c++) begin
        if (d[c] < lo_diff[c]) begin
          lo_diff[c] = d[c];
          lo_row[c] = p.row;
          lo_col[c] = p.col;
          if (d[c] < -int'(thr_main) && fall_cnt[c] != CntMax) fall_cnt[c]++;
          if (d[c] < -int'(thr_sub) && sub_cnt != SubMax) sub_cnt++;
        end
      end
    end
    if (p.fend) begin
      for (int c = 0; c < 3; c++) begin
        r.ch       = chan_t'(c);
        r.rise     = rise_t'(hi_diff[c]);
        r.rise_row = hi_row[c];
        r.rise_col = hi_col[c];
        r.fall     = diff_t'(lo_diff[c]);
        r.fall_row = lo_row[c];
        r.fall_col = lo_col[c];
        r.over     = rise_cnt[c];
        r.under    = fall_cnt[c];
        r.subt     = sub_cnt;
        r.last     = (chan_t'(c) == CH_BLUE);
        peaks_due.insert(peaks_due.size(), r);
      end
      clear_frame();
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    frame_peak_t e, a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a = '{channel_o, peak_rise_o, rise_row_o, rise_column_o, peak_fall_o, fall_row_o,
            fall_column_o, rises_over_o, falls_under_o, sub_total_o, last_o};
      if (peaks_due.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, a);
        fails++;
      end else begin
        e = peaks_due.pop_front();
        if (a.ch != e.ch) begin
          $display("%0t: channel expected %0d actual %0d", $time, e.ch, a.ch); fails++;
        end
        if (a.rise != e.rise) begin
          $display("%0t: peak_rise expected %0d actual %0d", $time, e.rise, a.rise); fails++;
        end
        if (a.rise_row != e.rise_row) begin
          $display("%0t: rise_row expected %0d actual %0d", $time, e.rise_row, a.rise_row);
          fails++;
        end
        if (a.rise_col != e.rise_col) begin
          $display("%0t: rise_column expected %0d actual %0d", $time, e.rise_col, a.rise_col);
          fails++;
        end
        if (a.fall != e.fall) begin
          $display("%0t: peak_fall expected %0d actual %0d", $time, e.fall, a.fall); fails++;
        end
        if (a.fall_row != e.fall_row) begin
          $display("%0t: fall_row expected %0d actual %0d", $time, e.fall_row, a.fall_row);
          fails++;
        end
        if (a.fall_col != e.fall_col) begin
          $display("%0t: fall_column expected %0d actual %0d", $time, e.fall_col, a.fall_col);
          fails++;
        end
        if (a.over != e.over) begin
          $display("%0t: rises_over expected %0d actual %0d", $time, e.over, a.over); fails++;
        end
        if (a.under != e.under) begin
          $display("%0t: falls_under expected %0d actual %0d", $time, e.under, a.under);
          fails++;
        end
        if (a.subt != e.subt) begin
          $display("%0t: sub_total expected %0d actual %0d", $time, e.subt, a.subt); fails++;
        end
        if (a.last != e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, a.last); fails++;
        end
      end
    end
  end

  // result receiver with random stalls and long hold-offs
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = draw_gap(rx_steady);
    end
  end

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = draw_gap(tx_steady);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    px_drv <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    fold_pixel(p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (peaks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_thresholds(input thr_t main_lvl, input thr_t sub_lvl);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MAIN_THR;
    cfg_wdata_i <= main_lvl;
    @(negedge clk_i);
    cfg_idx_i <= CFG_SUB_THR;
    cfg_wdata_i <= sub_lvl;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_main = main_lvl;
    thr_sub = sub_lvl;
  endtask

  function automatic pixel_t make_pixel(input int o0, o1, o2, n0, n1, n2,
                                        input int row, col, input bit excl, fend);
    pixel_t p;
    p.old_px = {pix_t'(o2), pix_t'(o1), pix_t'(o0)};
    p.new_px = {pix_t'(n2), pix_t'(n1), pix_t'(n0)};
    p.row = row[11:0];
    p.col = col[11:0];
    p.excl = excl;
    p.fend = fend;
    return p;
  endfunction

  function automatic pixel_t random_pixel(input bit fend, input int excl_pct);
    pixel_t p;
    int v;
    for (int c = 0; c < 3; c++) begin
      p.old_px[c] = pix_t'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        p.new_px[c] = pix_t'($urandom);
      end else begin
        v = int'(p.old_px[c]) + $urandom_range(0, 40) - 20;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        p.new_px[c] = pix_t'(v);
      end
    end
    p.row = 12'($urandom);
    p.col = 12'($urandom);
    p.excl = ($urandom_range(0, 99) < excl_pct);
    p.fend = fend;
    return p;
  endfunction

  // empty frames: only excluded pixels, so nothing is ever updated
  task automatic test_empty_frames();
    send_pixel(make_pixel(0, 0, 0, 255, 255, 255, 4095, 4095, 1, 1));
    send_pixel(make_pixel(255, 255, 255, 0, 0, 0, 17, 33, 1, 0));
    send_pixel(make_pixel(9, 200, 3, 250, 1, 77, 100, 200, 1, 1));
  endtask

  // extremes of the differences and coordinates, ties and exclusion
  task automatic test_extremes();
    set_thresholds(8'd0, 8'd0);
    send_pixel(make_pixel(0, 255, 10, 255, 0, 10, 0, 0, 0, 0));
    send_pixel(make_pixel(0, 255, 10, 255, 0, 10, 4095, 4095, 0, 0));
    send_pixel(make_pixel(10, 10, 0, 10, 10, 255, 2730, 1365, 0, 0));
    send_pixel(make_pixel(255, 0, 0, 0, 255, 0, 1365, 2730, 1, 0));
    send_pixel(make_pixel(128, 1, 255, 127, 2, 0, 4095, 0, 0, 1));
    send_pixel(make_pixel(5, 5, 5, 5, 5, 5, 12, 34, 0, 1));
    send_pixel(make_pixel(100, 0, 255, 99, 1, 255, 7, 8, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 4095, 1, 1));
  endtask

  // threshold edges, including both register extremes
  task automatic test_thresholds();
    set_thresholds(8'd255, 8'd255);
    send_pixel(make_pixel(0, 255, 0, 255, 0, 254, 1, 2, 0, 0));
    send_pixel(make_pixel(255, 0, 1, 0, 255, 0, 3, 4, 0, 1));
    set_thresholds(8'd254, 8'd0);
    send_pixel(make_pixel(0, 255, 1, 255, 0, 0, 5, 6, 0, 0));
    send_pixel(make_pixel(0, 0, 0, 254, 1, 0, 7, 8, 0, 0));
    send_pixel(make_pixel(255, 0, 0, 1, 0, 1, 9, 10, 0, 1));
    set_thresholds(8'd20, 8'd19);
    send_pixel(make_pixel(100, 100, 100, 120, 80, 119, 11, 12, 0, 0));
    send_pixel(make_pixel(100, 100, 100, 121, 79, 81, 13, 14, 0, 1));
  endtask

  // long receiver hold-off while pixels keep coming
  task automatic test_backpressure();
    set_thresholds(8'd3, 8'd1);
    tx_steady = 1'b1;
    hold_request = 80;
    for (int i = 0; i < 30; i++) send_pixel(random_pixel(i % 2 == 1, 10));
    tx_steady = 1'b0;
  endtask

  // random frames of random length, thresholds changed now and then
  task automatic test_random_frames();
    int sent, len;
    sent = 0;
    while (sent < 50) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_thresholds(8'd0, 8'd255);
          1: set_thresholds(8'd255, 8'd0);
          default: set_thresholds(thr_t'($urandom_range(0, 40)), thr_t'($urandom));
        endcase
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      for (int i = 0; i < len; i++) send_pixel(random_pixel(i == len - 1, 10));
      sent += len;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAIN_THR;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    px_drv = '0;
    out_ready_i = 1'b0;
    fails = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_request = 0;
    hold_left = 0;
    stall_left = 0;
    thr_main = '0;
    thr_sub = '0;
    clear_frame();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_frames();
    test_extremes();
    test_thresholds();
    test_backpressure();
    test_random_frames();

    drain();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
